[hdl/inverse_affine_image_warp_core_assert.svh]
// Assertion macros shared by the warp core.
`ifndef INVERSE_AFFINE_IMAGE_WARP_CORE_ASSERT_SVH
`define INVERSE_AFFINE_IMAGE_WARP_CORE_ASSERT_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define IAW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("warp core check failed");

// A condition that must never hold.
`define IAW_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("warp core exclusion failed");

`endif

[hdl/iaw_pkg.sv]
package iaw_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ROW_SHIFT = 3'd0,
        CFG_COL_SHIFT = 3'd1,
        CFG_ANGLE     = 3'd2,
        CFG_SCALE     = 3'd3,
        CFG_ROWS      = 3'd4,
        CFG_COLS      = 3'd5
    } t_cfg_idx;

    // Item opcodes.
    typedef enum logic {
        OP_STORE = 1'b0,
        OP_FETCH = 1'b1
    } t_opcode;

    localparam logic [15:0] SCALE_RESET = 16'd4096;
    localparam logic [8:0]  SIZE_RESET  = 9'd256;

    // Quotient bits produced by the divider before saturation.
    localparam int QUOT_BITS = 17;

    // Sine table over whole degrees 0..90, wide enough for twenty fraction bits.
    localparam int SINE_ENTRIES = 91;
    localparam int SINE_W       = 21;
    localparam longint PI_Q30   = 64'sd3373259426;

    typedef logic [SINE_W-1:0] t_sine_rom [SINE_ENTRIES];

    // Taylor series of the sine in Q30, evaluated at elaboration.
    function automatic longint taylor_sine_q30(longint x);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 12; k++) begin
            term = (term * x2) >>> 30;
            case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                7:       term = term / 210;
                8:       term = term / 272;
                9:       term = term / 342;
                10:      term = term / 420;
                11:      term = term / 506;
                12:      term = term / 600;
                default: term = term;
            endcase
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Quarter-wave sine table rounded half up to the given fraction bits.
    function automatic t_sine_rom build_sine_rom(int frac_bits);
        t_sine_rom rom;
        longint    x;
        longint    v;
        for (int d = 0; d < SINE_ENTRIES; d++) begin
            x = (longint'(d) * PI_Q30 + 90) / 180;
            v = taylor_sine_q30(x);
            if (v < 0) begin
                v = 0;
            end
            v = (v + (longint'(1) <<< (29 - frac_bits))) >>> (30 - frac_bits);
            rom[d] = SINE_W'(v);
        end
        return rom;
    endfunction

    // Saturate a sign and magnitude quotient to a signed 16-bit coordinate.
    function automatic logic signed [15:0] sat_quot(logic neg, logic ovf,
                                                    logic [QUOT_BITS-1:0] q);
        logic signed [15:0] res;
        if (neg) begin
            if (ovf || q > 17'd32768) begin
                res = 16'sh8000;
            end else begin
                res = -$signed(q[15:0]);
            end
        end else begin
            if (ovf || q > 17'd32767) begin
                res = 16'sh7FFF;
            end else begin
                res = $signed(q[15:0]);
            end
        end
        return res;
    endfunction

endpackage

[hdl/inverse_affine_image_warp_core.sv]
// Channel   Direction  Handshake                    Beat contents
// in        input      i_in_valid / o_in_ready      opcode, row, col, pixel_in
// out       output     o_out_valid / i_out_ready    pixel_out, inside_res, src_row, src_col
// cfg       input      i_cfg_wr_en                  register index, write data
//
// One item is taken every cycle unless a stalled output beat holds the pipeline; only fetches give a beat.
// The restoring divider produces one quotient bit per stage.
// Stores travel the same pipeline and write the image memory at the read stage, so
// the single memory port sees one access a cycle in item order.
// Reset clears valid flags and returns configuration to its defaults; the image memory is not cleared.
// A stalled output beat freezes the whole pipeline and drops o_in_ready.
`include "inverse_affine_image_warp_core_assert.svh"

module inverse_affine_image_warp_core import iaw_pkg::*; #(
    parameter int MAX_ROWS       = 256,
    parameter int MAX_COLS       = 256,
    parameter int PIXEL_BITS     = 8,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [7:0]         i_row,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_pixel_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_pixel_out,
    output logic               o_inside_res,
    output logic signed [15:0] o_src_row,
    output logic signed [15:0] o_src_col
);

    localparam int F      = TRIG_FRAC_BITS;
    localparam int PW     = PIXEL_BITS;
    localparam int RB     = $clog2(MAX_ROWS);
    localparam int CB     = $clog2(MAX_COLS);
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int TW     = 17 + PW;
    localparam int CS_W   = F + 2;
    localparam int PROD_W = F + 14;
    localparam int NUM_W  = F + 15;
    localparam logic [12:0]   ROW_CAP = 13'(MAX_ROWS);
    localparam logic [12:0]   COL_CAP = 13'(MAX_COLS);
    localparam logic [AW-1:0] PITCH   = AW'(MAX_COLS);

    // Configuration registers.
    logic signed [10:0] r_row_shift;
    logic signed [10:0] r_col_shift;
    logic signed [9:0]  r_angle;
    logic [15:0]        r_scale;
    logic [8:0]         r_rows;
    logic [8:0]         r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_shift <= '0;
            r_col_shift <= '0;
            r_angle     <= '0;
            r_scale     <= SCALE_RESET;
            r_rows      <= SIZE_RESET;
            r_cols      <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ROW_SHIFT: r_row_shift <= i_cfg_wdata[10:0];
                CFG_COL_SHIFT: r_col_shift <= i_cfg_wdata[10:0];
                CFG_ANGLE:     r_angle     <= i_cfg_wdata[9:0];
                CFG_SCALE:     r_scale     <= i_cfg_wdata;
                CFG_ROWS:      r_rows      <= i_cfg_wdata[8:0];
                CFG_COLS:      r_cols      <= i_cfg_wdata[8:0];
                default:       r_rows      <= r_rows;
            endcase
        end
    end

    // Pipeline advances unless the output beat is held.
    logic w_en;
    logic r_f_valid;

    assign w_en       = !(r_f_valid && !i_out_ready);
    assign o_in_ready = w_en;

    // Stage A: capture the item as a tag of opcode, row, column and pixel.
    logic [PW+7:0]   w_pix_in_ext;
    logic            r_a_valid;
    logic [TW-1:0]   r_a_tag;

    assign w_pix_in_ext = {{PW{1'b0}}, i_pixel_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
        end
        if (w_en) begin
            r_a_tag <= {i_opcode, i_row, i_col, w_pix_in_ext[PW-1:0]};
        end
    end

    // Stage B: shifted coordinates and the sine and cosine of the angle.
    logic signed [CS_W-1:0] w_cos;
    logic signed [CS_W-1:0] w_sin;
    logic                   r_b_valid;
    logic [TW-1:0]          r_b_tag;
    logic signed [11:0]     r_b_a;
    logic signed [11:0]     r_b_b;
    logic signed [CS_W-1:0] r_b_cos;
    logic signed [CS_W-1:0] r_b_sin;

    iaw_trig #(
        .FRAC_BITS (F)
    ) u_trig (
        .i_angle (r_angle),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
        if (w_en) begin
            r_b_tag <= r_a_tag;
            r_b_a   <= $signed({4'b0000, r_a_tag[TW-2 -: 8]})
                       - {r_row_shift[10], r_row_shift};
            r_b_b   <= $signed({4'b0000, r_a_tag[TW-10 -: 8]})
                       - {r_col_shift[10], r_col_shift};
            r_b_cos <= w_cos;
            r_b_sin <= w_sin;
        end
    end

    // Stage C: the four products.
    logic                     r_c_valid;
    logic [TW-1:0]            r_c_tag;
    logic signed [PROD_W-1:0] r_c_ca;
    logic signed [PROD_W-1:0] r_c_sb;
    logic signed [PROD_W-1:0] r_c_cb;
    logic signed [PROD_W-1:0] r_c_sa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
        if (w_en) begin
            r_c_tag <= r_b_tag;
            r_c_ca  <= r_b_cos * r_b_a;
            r_c_sb  <= r_b_sin * r_b_b;
            r_c_cb  <= r_b_cos * r_b_b;
            r_c_sa  <= r_b_sin * r_b_a;
        end
    end

    // Stage D: numerators split into sign and magnitude.
    logic signed [NUM_W-1:0] w_num_r;
    logic signed [NUM_W-1:0] w_num_c;
    logic                    r_d_valid;
    logic [TW-1:0]           r_d_tag;
    logic                    r_d_neg_r;
    logic                    r_d_neg_c;
    logic [NUM_W-1:0]        r_d_mag_r;
    logic [NUM_W-1:0]        r_d_mag_c;

    assign w_num_r = NUM_W'(r_c_ca) + NUM_W'(r_c_sb);
    assign w_num_c = NUM_W'(r_c_cb) - NUM_W'(r_c_sa);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
        if (w_en) begin
            r_d_tag   <= r_c_tag;
            r_d_neg_r <= w_num_r[NUM_W-1];
            r_d_neg_c <= w_num_c[NUM_W-1];
            r_d_mag_r <= w_num_r[NUM_W-1] ? NUM_W'(-w_num_r) : NUM_W'(w_num_r);
            r_d_mag_c <= w_num_c[NUM_W-1] ? NUM_W'(-w_num_c) : NUM_W'(w_num_c);
        end
    end

    // Divider pipeline for both coordinates; a zero scale acts as one.
    logic [15:0]          w_scale_eff;
    logic                 w_dv_valid;
    logic [TW-1:0]        w_dv_tag;
    logic                 w_dv_neg_r;
    logic                 w_dv_ovf_r;
    logic [QUOT_BITS-1:0] w_dv_q_r;
    logic                 w_dv_neg_c;
    logic                 w_dv_ovf_c;
    logic [QUOT_BITS-1:0] w_dv_q_c;

    assign w_scale_eff = (r_scale == 16'd0) ? 16'd1 : r_scale;

    iaw_div #(
        .FRAC_BITS (F),
        .TAG_W     (TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_valid),
        .i_tag   (r_d_tag),
        .i_scale (w_scale_eff),
        .i_neg_r (r_d_neg_r),
        .i_mag_r (r_d_mag_r),
        .i_neg_c (r_d_neg_c),
        .i_mag_c (r_d_mag_c),
        .o_valid (w_dv_valid),
        .o_tag   (w_dv_tag),
        .o_neg_r (w_dv_neg_r),
        .o_ovf_r (w_dv_ovf_r),
        .o_q_r   (w_dv_q_r),
        .o_neg_c (w_dv_neg_c),
        .o_ovf_c (w_dv_ovf_c),
        .o_q_c   (w_dv_q_c)
    );

    // Stage E: saturate, test against the image in use and form the address.
    logic signed [15:0] w_sr;
    logic signed [15:0] w_sc;
    logic [12:0]        w_rlim;
    logic [12:0]        w_clim;
    logic               w_inside;
    logic               w_dv_op;
    logic [7:0]         w_dv_row;
    logic [7:0]         w_dv_col;
    logic               w_st_ok;
    logic [AW-1:0]      w_addr;

    assign w_sr     = sat_quot(w_dv_neg_r, w_dv_ovf_r, w_dv_q_r);
    assign w_sc     = sat_quot(w_dv_neg_c, w_dv_ovf_c, w_dv_q_c);
    assign w_rlim   = ({4'b0000, r_rows} > ROW_CAP) ? ROW_CAP : {4'b0000, r_rows};
    assign w_clim   = ({4'b0000, r_cols} > COL_CAP) ? COL_CAP : {4'b0000, r_cols};
    assign w_inside = !w_sr[15] && !w_sc[15]
                      && (w_sr < $signed({3'b000, w_rlim}))
                      && (w_sc < $signed({3'b000, w_clim}));
    assign w_dv_op  = w_dv_tag[TW-1];
    assign w_dv_row = w_dv_tag[TW-2 -: 8];
    assign w_dv_col = w_dv_tag[TW-10 -: 8];
    assign w_st_ok  = ({5'b00000, w_dv_row} < ROW_CAP) && ({5'b00000, w_dv_col} < COL_CAP);

    always_comb begin
        if (w_dv_op == OP_FETCH) begin
            w_addr = AW'(w_sr[RB-1:0]) * PITCH + AW'(w_sc[CB-1:0]);
        end else begin
            w_addr = AW'(w_dv_row) * PITCH + AW'(w_dv_col);
        end
    end

    logic               r_e_valid;
    logic               r_e_op;
    logic               r_e_st_ok;
    logic               r_e_inside;
    logic signed [15:0] r_e_sr;
    logic signed [15:0] r_e_sc;
    logic [AW-1:0]      r_e_addr;
    logic [PW-1:0]      r_e_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= w_dv_valid;
        end
        if (w_en) begin
            r_e_op     <= w_dv_op;
            r_e_st_ok  <= w_st_ok;
            r_e_inside <= w_inside;
            r_e_sr     <= w_sr;
            r_e_sc     <= w_sc;
            r_e_addr   <= w_addr;
            r_e_wdata  <= w_dv_tag[PW-1:0];
        end
    end

    // Image memory: a store writes, a fetch reads, one access per cycle.
    logic          w_ram_we;
    logic          w_ram_re;
    logic [PW-1:0] w_ram_q;

    assign w_ram_we = w_en && r_e_valid && (r_e_op == OP_STORE) && r_e_st_ok;
    assign w_ram_re = w_en && r_e_valid && (r_e_op == OP_FETCH);

    iaw_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (r_e_addr),
        .i_wdata (r_e_wdata),
        .o_rdata (w_ram_q)
    );

    // Stage F: output register alongside the memory read data.
    logic               r_f_inside;
    logic signed [15:0] r_f_sr;
    logic signed [15:0] r_f_sc;
    logic [PW+7:0]      w_pix_out_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= r_e_valid && (r_e_op == OP_FETCH);
        end
        if (w_en) begin
            r_f_inside <= r_e_inside;
            r_f_sr     <= r_e_sr;
            r_f_sc     <= r_e_sc;
        end
    end

    assign w_pix_out_ext = {8'b0, w_ram_q};
    assign o_out_valid   = r_f_valid;
    assign o_inside_res  = r_f_inside;
    assign o_pixel_out   = r_f_inside ? w_pix_out_ext[7:0] : 8'd0;
    assign o_src_row     = r_f_sr;
    assign o_src_col     = r_f_sc;

    // Checks on the pipeline and memory port.
    `IAW_ASSERT_NEVER(a_ram_one_access, i_clk, i_rst_n, w_ram_we && w_ram_re)
    `IAW_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `IAW_ASSERT_NOW(a_inside_nonneg, i_clk, i_rst_n, o_out_valid && o_inside_res, !o_src_row[15] && !o_src_col[15])

endmodule

[hdl/iaw_ram.sv]
module iaw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/iaw_trig.sv]
module iaw_trig import iaw_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic signed [9:0]           i_angle,
    output logic signed [FRAC_BITS+1:0] o_cos,
    output logic signed [FRAC_BITS+1:0] o_sin
);

    localparam int TW = FRAC_BITS + 2;
    localparam t_sine_rom SINE_ROM = build_sine_rom(FRAC_BITS);

    // Sine of a reduced angle 0..359 by quadrant symmetry.
    function automatic logic signed [TW-1:0] sine_of(logic [8:0] d);
        logic [6:0]    idx;
        logic          neg;
        logic [TW-1:0] mag;
        priority if (d <= 9'd90) begin
            idx = d[6:0];
            neg = 1'b0;
        end else if (d <= 9'd180) begin
            idx = 7'(9'd180 - d);
            neg = 1'b0;
        end else if (d <= 9'd270) begin
            idx = 7'(d - 9'd180);
            neg = 1'b1;
        end else begin
            idx = 7'(9'd360 - d);
            neg = 1'b1;
        end
        mag = TW'(SINE_ROM[idx][FRAC_BITS:0]);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    logic signed [10:0] w_red;
    logic [8:0]         w_sin_deg;
    logic [9:0]         w_cos_sum;
    logic [8:0]         w_cos_deg;

    // Reduce the angle modulo 360 and derive the cosine angle.
    always_comb begin
        w_red = {i_angle[9], i_angle};
        if (w_red >= 11'sd360) begin
            w_red = w_red - 11'sd360;
        end else if (w_red <= -11'sd360) begin
            w_red = w_red + 11'sd360;
        end
        if (w_red < 11'sd0) begin
            w_red = w_red + 11'sd360;
        end
        w_sin_deg = w_red[8:0];
        w_cos_sum = {1'b0, w_sin_deg} + 10'd90;
        if (w_cos_sum >= 10'd360) begin
            w_cos_sum = w_cos_sum - 10'd360;
        end
        w_cos_deg = w_cos_sum[8:0];
    end

    assign o_sin = sine_of(w_sin_deg);
    assign o_cos = sine_of(w_cos_deg);

endmodule

[hdl/iaw_div.sv]
module iaw_div import iaw_pkg::*; #(
    parameter int FRAC_BITS = 14,
    parameter int TAG_W     = 25
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [TAG_W-1:0]         i_tag,
    input  logic [15:0]              i_scale,
    input  logic                     i_neg_r,
    input  logic [FRAC_BITS+14:0]    i_mag_r,
    input  logic                     i_neg_c,
    input  logic [FRAC_BITS+14:0]    i_mag_c,
    output logic                     o_valid,
    output logic [TAG_W-1:0]         o_tag,
    output logic                     o_neg_r,
    output logic                     o_ovf_r,
    output logic [QUOT_BITS-1:0]     o_q_r,
    output logic                     o_neg_c,
    output logic                     o_ovf_c,
    output logic [QUOT_BITS-1:0]     o_q_c
);

    localparam int W  = FRAC_BITS + 34;
    localparam int QB = QUOT_BITS;

    logic [W-1:0] w_den;
    logic [W-1:0] w_num [2];
    logic         w_neg [2];

    logic             r_valid [QB+1];
    logic [TAG_W-1:0] r_tag   [QB+1];
    logic [W-1:0]     r_rem   [2][QB];
    logic [QB-1:0]    r_q     [2][QB+1];
    logic             r_ovf   [2][QB+1];
    logic             r_neg   [2][QB+1];

    logic [W-1:0]  n_rem [2][QB];
    logic [QB-1:0] n_q   [2][QB+1];
    logic [W-1:0]  w_trial [QB];

    // Divisor is the scale moved up by the trig fraction bits.
    assign w_den    = W'(i_scale) << FRAC_BITS;
    assign w_num[0] = W'(i_mag_r) << 12;
    assign w_num[1] = W'(i_mag_c) << 12;
    assign w_neg[0] = i_neg_r;
    assign w_neg[1] = i_neg_c;

    // Restoring division: one quotient bit per stage, most significant first.
    always_comb begin
        for (int s = 0; s < QB; s++) begin
            w_trial[s] = w_den << (QB - 1 - s);
        end
        for (int l = 0; l < 2; l++) begin
            n_rem[l][0] = w_num[l];
            n_q[l][0]   = '0;
            for (int s = 1; s <= QB; s++) begin
                n_q[l][s] = r_q[l][s-1];
                if (r_rem[l][s-1] >= w_trial[s-1]) begin
                    n_q[l][s][QB-s] = 1'b1;
                    if (s < QB) begin
                        n_rem[l][s] = r_rem[l][s-1] - w_trial[s-1];
                    end
                end else if (s < QB) begin
                    n_rem[l][s] = r_rem[l][s-1];
                end
            end
        end
    end

    // Stage registers; the first stage also flags quotients beyond the bit range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s <= QB; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int s = 1; s <= QB; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
            for (int l = 0; l < 2; l++) begin
                r_ovf[l][0] <= w_num[l] >= (w_den << QB);
                r_neg[l][0] <= w_neg[l];
                for (int s = 0; s < QB; s++) begin
                    r_rem[l][s] <= n_rem[l][s];
                end
                for (int s = 0; s <= QB; s++) begin
                    r_q[l][s] <= n_q[l][s];
                end
                for (int s = 1; s <= QB; s++) begin
                    r_ovf[l][s] <= r_ovf[l][s-1];
                    r_neg[l][s] <= r_neg[l][s-1];
                end
            end
        end
    end

    assign o_valid = r_valid[QB];
    assign o_tag   = r_tag[QB];
    assign o_neg_r = r_neg[0][QB];
    assign o_ovf_r = r_ovf[0][QB];
    assign o_q_r   = r_q[0][QB];
    assign o_neg_c = r_neg[1][QB];
    assign o_ovf_c = r_ovf[1][QB];
    assign o_q_c   = r_q[1][QB];

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iaw_pkg::*;

    localparam int GAP_MAX     = 19;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 2_000_000;

    // One predicted output beat.
    typedef struct {
        logic [7:0]         pixel;
        logic               hit;
        logic signed [15:0] src_row;
        logic signed [15:0] src_col;
    } t_warp_beat;

    // Predicts the warp core and checks its output beats in order.
    class warp_scoreboard;
        longint             sines [91];
        logic [7:0]         image [65536];
        logic signed [10:0] row_shift;
        logic signed [10:0] col_shift;
        logic signed [9:0]  angle;
        logic [15:0]        scale;
        logic [8:0]         rows;
        logic [8:0]         cols;
        t_warp_beat         expected_pixels [$];
        int                 mismatches;

        function new();
            longint x;
            longint x2;
            longint term;
            longint sum;
            // Quarter-wave sine in Q30 by Taylor series, then rounded to Q1.14.
            for (int d = 0; d <= 90; d++) begin
                x    = (longint'(d) * 64'sd3373259426 + 90) / 180;
                x2   = (x * x) >>> 30;
                term = x;
                sum  = x;
                for (int k = 1; k <= 12; k++) begin
                    term = ((term * x2) >>> 30) / longint'((2 * k) * (2 * k + 1));
                    sum  = (k % 2 == 1) ? sum - term : sum + term;
                end
                if (sum < 0) begin
                    sum = 0;
                end
                sines[d] = (sum + (longint'(1) << 15)) >>> 16;
            end
            row_shift  = '0;
            col_shift  = '0;
            angle      = '0;
            scale      = SCALE_RESET;
            rows       = SIZE_RESET;
            cols       = SIZE_RESET;
            mismatches = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_ROW_SHIFT: row_shift = value[10:0];
                CFG_COL_SHIFT: col_shift = value[10:0];
                CFG_ANGLE:     angle     = value[9:0];
                CFG_SCALE:     scale     = value;
                CFG_ROWS:      rows      = value[8:0];
                CFG_COLS:      cols      = value[8:0];
                default:       ;
            endcase
        endfunction

        // Whole-degree sine with quadrant folding.
        function longint sine_of(int deg);
            int a;
            a = deg % 360;
            if (a < 0) begin
                a += 360;
            end
            if (a <= 90) begin
                return sines[a];
            end else if (a <= 180) begin
                return sines[180 - a];
            end else if (a <= 270) begin
                return -sines[a - 180];
            end
            return -sines[360 - a];
        endfunction

        // Truncating quotient on magnitudes, saturated to 16 bits.
        function logic signed [15:0] mapped_coord(longint num);
            longint mag;
            longint den;
            longint q;
            mag = (num < 0) ? -num : num;
            den = longint'((scale == 0) ? 16'd1 : scale) << 14;
            q   = (mag << 12) / den;
            if (num < 0) begin
                return (q > 32768) ? -16'sd32768 : 16'(-q);
            end
            return (q > 32767) ? 16'sd32767 : 16'(q);
        endfunction

        function void note_item(t_opcode op, logic [7:0] row, logic [7:0] col,
                                logic [7:0] pix);
            t_warp_beat beat;
            longint     c;
            longint     s;
            longint     a;
            longint     b;
            int         rlim;
            int         clim;
            if (op == OP_STORE) begin
                image[{row, col}] = pix;
                return;
            end
            c = sine_of(int'(angle) + 90);
            s = sine_of(int'(angle));
            a = longint'(row) - longint'(row_shift);
            b = longint'(col) - longint'(col_shift);
            beat.src_row = mapped_coord(c * a + s * b);
            beat.src_col = mapped_coord(c * b - s * a);
            rlim = (rows > 256) ? 256 : int'(rows);
            clim = (cols > 256) ? 256 : int'(cols);
            beat.hit = beat.src_row >= 0 && beat.src_col >= 0
                       && int'(beat.src_row) < rlim && int'(beat.src_col) < clim;
            beat.pixel = beat.hit ? image[{beat.src_row[7:0], beat.src_col[7:0]}] : 8'd0;
            expected_pixels.push_back(beat);
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_pixel(logic [7:0] pixel, logic in_img, logic signed [15:0] srow,
                         logic signed [15:0] scol);
            t_warp_beat want;
            if (expected_pixels.size() == 0) begin
                report("output beat with nothing outstanding");
                return;
            end
            want = expected_pixels.pop_front();
            if (pixel !== want.pixel || in_img !== want.hit || srow !== want.src_row
                    || scol !== want.src_col) begin
                report($sformatf("got pix %0d in %0b at (%0d,%0d), want %0d %0b (%0d,%0d)",
                       pixel, in_img, srow, scol, want.pixel, want.hit,
                       want.src_row, want.src_col));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_opcode;
    logic [7:0]         i_row;
    logic [7:0]         i_col;
    logic [7:0]         i_pixel_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [7:0]         o_pixel_out;
    logic               o_inside_res;
    logic signed [15:0] o_src_row;
    logic signed [15:0] o_src_col;

    warp_scoreboard sb;
    bit             no_gaps;
    int             out_stall = 0;
    longint         cycles = 0;

    inverse_affine_image_warp_core dut (.*);

    // Clock and cycle watchdog.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: check each beat, then draw a stall for the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
        end else begin
            if (o_out_valid && i_out_ready) begin
                sb.check_pixel(o_pixel_out, o_inside_res, o_src_row, o_src_col);
                out_stall = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
                if (out_stall > 0) begin
                    i_out_ready <= 1'b0;
                end
            end else if (!i_out_ready) begin
                out_stall--;
                if (out_stall <= 0) begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    task write_register(t_cfg_idx idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        sb.set_register(idx, value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Present one input beat after an optional gap and hold it until taken.
    task send_item(t_opcode op, logic [7:0] row, logic [7:0] col, logic [7:0] pix);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_row      <= row;
        i_col      <= col;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(op, row, col, pix);
    endtask

    // Let the pipeline run dry before touching the registers.
    task drain();
        i_in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task set_warp(int rs, int cs, int ang, int scl, int nr, int nc);
        write_register(CFG_ROW_SHIFT, 16'(rs));
        write_register(CFG_COL_SHIFT, 16'(cs));
        write_register(CFG_ANGLE, 16'(ang));
        write_register(CFG_SCALE, 16'(scl));
        write_register(CFG_ROWS, 16'(nr));
        write_register(CFG_COLS, 16'(nc));
    endtask

    task random_items(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(OP_STORE, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_item(OP_FETCH, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        sb          = new();
        no_gaps     = 1'b1;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_STORE;
        i_row       = '0;
        i_col       = '0;
        i_pixel_in  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill a 16 by 16 block first; every later phase that can land inside keeps
        // the image in use within this block or within pixels stored just before.
        for (int r = 0; r < 16; r++) begin
            for (int c = 0; c < 16; c++) begin
                send_item(OP_STORE, 8'(r), 8'(c), 8'($urandom));
            end
        end

        // Directed beats at reset settings: corners, extreme values, identity map.
        no_gaps = 1'b0;
        send_item(OP_STORE, 8'd0, 8'd0, 8'd255);
        send_item(OP_STORE, 8'd255, 8'd255, 8'd0);
        send_item(OP_STORE, 8'd0, 8'd255, 8'd17);
        send_item(OP_STORE, 8'd255, 8'd0, 8'd200);
        send_item(OP_FETCH, 8'd0, 8'd0, 8'd0);
        send_item(OP_FETCH, 8'd255, 8'd255, 8'd255);
        send_item(OP_FETCH, 8'd0, 8'd255, 8'd0);
        send_item(OP_FETCH, 8'd255, 8'd0, 8'd0);
        drain();

        // Extreme shifts and angles, zero and oversized image sizes, zero scale.
        set_warp(-1023, 1023, -359, 0, 0, 511);
        send_item(OP_FETCH, 8'd0, 8'd0, 8'd0);
        send_item(OP_FETCH, 8'd255, 8'd255, 8'd0);
        drain();
        set_warp(1023, -1023, 359, 65535, 511, 0);
        send_item(OP_FETCH, 8'd0, 8'd0, 8'd0);
        send_item(OP_FETCH, 8'd255, 8'd255, 8'd0);
        drain();
        set_warp(0, 0, 90, 256, 1, 1);
        send_item(OP_FETCH, 8'd0, 8'd0, 8'd0);
        send_item(OP_FETCH, 8'd3, 8'd3, 8'd0);
        drain();

        // Random phases over a spread of settings; one phase runs without gaps.
        set_warp(0, 0, 0, 65535, 16, 16);
        random_items(160);
        drain();
        set_warp(128, 128, 45, 32768, 16, 16);
        random_items(160);
        drain();
        set_warp(-200, 300, 180, 2048, 16, 12);
        no_gaps = 1'b1;
        random_items(130);
        no_gaps = 1'b0;
        drain();
        set_warp(50, -50, -90, 40000, 16, 16);
        random_items(150);
        drain();
        set_warp(1023, 1023, 270, 256, 16, 16);
        random_items(110);
        drain();
        set_warp($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 719) - 359,
                 $urandom_range(2048, 12000), 16, 16);
        random_items(160);
        drain();
        set_warp(0, 0, -359, 65535, 16, 16);
        random_items(110);
        drain();
        set_warp(-100, 60, 123, 3000, 16, 16);
        random_items(160);
        drain();

        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
